### src/dla_pkg.sv
// Shared types and codes for the distributed lock arbiter.
// No dependencies; every other source file imports this package.
`timescale 1ns / 1ps

package dla_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned PORT_W  = 16;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [2:0] {
    OP_LOCAL_REQ   = 3'd0,
    OP_LOCAL_REL   = 3'd1,
    OP_REMOTE_REQ  = 3'd2,
    OP_REMOTE_REL  = 3'd3,
    OP_GRANT       = 3'd4,
    OP_DENY        = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    PH_AVAILABLE  = 2'd0,
    PH_REQUESTING = 2'd1,
    PH_REMOTE     = 2'd2,
    PH_OURS       = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    SEND_NONE    = 3'd0,
    SEND_REQUEST = 3'd1,
    SEND_RELEASE = 3'd2,
    SEND_GRANT   = 3'd3,
    SEND_DENY    = 3'd4
  } send_t;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_GRANTED  = 2'd1,
    EV_DENIED   = 2'd2,
    EV_RELEASED = 2'd3
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MY_ADDRESS = 2'd0,
    CFG_MY_PORT    = 2'd1,
    CFG_PEER_COUNT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    phase_t              phase;
    logic [ADDR_W-1:0]   holder_address;
    logic [PORT_W-1:0]   holder_port;
    logic [COUNT_W-1:0]  grants_seen;
  } lock_state_t;

  typedef struct packed {
    send_t               send_kind;
    logic [ADDR_W-1:0]   send_address;
    logic [PORT_W-1:0]   send_port;
    event_t              event_res;
    phase_t              lock_state;
    logic                release_mismatch;
  } result_t;

endpackage

### src/dla_step.sv
// Next-state and result logic for one lock protocol message.
// Depends on dla_pkg.
`timescale 1ns / 1ps

module dla_step (
  input  logic [2:0]                   op,
  input  logic [dla_pkg::ADDR_W-1:0]   sender_address,
  input  logic [dla_pkg::PORT_W-1:0]   sender_port,
  input  logic [dla_pkg::ADDR_W-1:0]   my_address,
  input  logic [dla_pkg::PORT_W-1:0]   my_port,
  input  logic [dla_pkg::COUNT_W-1:0]  peers_needed,
  input  dla_pkg::lock_state_t         cur,
  output dla_pkg::lock_state_t         nxt,
  output dla_pkg::result_t             res
);
  import dla_pkg::*;

  logic                for_me;
  logic                lower;
  logic                wins;
  logic [COUNT_W-1:0]  grants_inc;

  assign for_me = (sender_address == my_address) && (sender_port == my_port);
  // address first, then port
  assign lower = (sender_address < cur.holder_address) ||
                 ((sender_address == cur.holder_address) &&
                  (sender_port < cur.holder_port));
  assign wins = (cur.phase == PH_AVAILABLE) ||
                (((cur.phase == PH_REMOTE) || (cur.phase == PH_REQUESTING)) && lower);
  assign grants_inc = (cur.grants_seen != {COUNT_W{1'b1}}) ?
                      cur.grants_seen + COUNT_W'(1) : cur.grants_seen;

  always_comb begin
    nxt = cur;
    res.send_kind        = SEND_NONE;
    res.send_address     = '0;
    res.send_port        = '0;
    res.event_res        = EV_NONE;
    res.release_mismatch = 1'b0;
    unique case (op)
      OP_LOCAL_REQ: begin
        if (cur.phase == PH_AVAILABLE) begin
          if (peers_needed == '0) begin
            nxt.phase     = PH_OURS;
            res.event_res = EV_GRANTED;
          end else begin
            nxt.phase          = PH_REQUESTING;
            nxt.grants_seen    = '0;
            nxt.holder_address = my_address;
            nxt.holder_port    = my_port;
            res.send_kind      = SEND_REQUEST;
            res.send_address   = my_address;
            res.send_port      = my_port;
          end
        end
      end
      OP_LOCAL_REL: begin
        if (cur.phase == PH_OURS) begin
          nxt.phase          = PH_AVAILABLE;
          nxt.holder_address = '0;
          nxt.holder_port    = '0;
          if (peers_needed != '0) begin
            res.send_kind    = SEND_RELEASE;
            res.send_address = my_address;
            res.send_port    = my_port;
          end
          res.event_res = EV_RELEASED;
        end
      end
      OP_REMOTE_REQ: begin
        if (wins) begin
          nxt.holder_address = sender_address;
          nxt.holder_port    = sender_port;
          nxt.phase          = PH_REMOTE;
          res.send_kind      = SEND_GRANT;
        end else begin
          res.send_kind      = SEND_DENY;
        end
        res.send_address = sender_address;
        res.send_port    = sender_port;
      end
      OP_REMOTE_REL: begin
        // no holder while available, so that is a mismatch too
        res.release_mismatch = (cur.phase == PH_AVAILABLE) ||
                               (sender_address != cur.holder_address) ||
                               (sender_port != cur.holder_port);
        nxt.phase          = PH_AVAILABLE;
        nxt.holder_address = '0;
        nxt.holder_port    = '0;
        res.event_res      = EV_RELEASED;
      end
      OP_GRANT: begin
        if (for_me) begin
          nxt.grants_seen = grants_inc;
          if (grants_inc >= peers_needed) begin
            nxt.phase     = PH_OURS;
            res.event_res = EV_GRANTED;
          end
        end
      end
      OP_DENY: begin
        if (for_me) begin
          nxt.grants_seen = '0;
          res.event_res   = EV_DENIED;
        end
      end
      default: begin
      end
    endcase
    res.lock_state = nxt.phase;
  end

endmodule

### src/distributed_lock_arbiter_unit.sv
// An accepted item passes through the input register, then the result register. One item
// per cycle unless stalled; the lock state updates as an item leaves the input register.
// Both stages advance together, so a stalled output only holds the pipe, never drops an item.
// Reset (rst_n low, synchronous): pipe empty, lock available, holder and grant count zero,
// configuration registers zero.
// Depends on dla_pkg and dla_step.
`timescale 1ns / 1ps

module distributed_lock_arbiter_unit #(
  parameter int unsigned MAX_PEERS = 255
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [dla_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dla_pkg::ADDR_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_operation,
  input  logic [dla_pkg::ADDR_W-1:0]    in_sender_address,
  input  logic [dla_pkg::PORT_W-1:0]    in_sender_port,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_send_kind,
  output logic [dla_pkg::ADDR_W-1:0]    out_send_address,
  output logic [dla_pkg::PORT_W-1:0]    out_send_port,
  output logic [1:0]                    out_event_res,
  output logic [1:0]                    out_lock_state,
  output logic                          out_release_mismatch
);
  import dla_pkg::*;

  localparam int unsigned CAP = (MAX_PEERS > 255) ? 255 : MAX_PEERS;
  localparam logic [COUNT_W-1:0] CAP_W = COUNT_W'(CAP);

  logic [ADDR_W-1:0]  my_address_r;
  logic [PORT_W-1:0]  my_port_r;
  logic [COUNT_W-1:0] peer_count_r;
  logic [COUNT_W-1:0] peers_needed;

  logic               in_valid_r;
  logic [2:0]         in_op_r;
  logic [ADDR_W-1:0]  in_addr_r;
  logic [PORT_W-1:0]  in_port_r;

  lock_state_t        state_r;
  lock_state_t        state_nxt;
  result_t            res_nxt;
  result_t            res_r;
  logic               out_valid_r;
  logic               advance;

  assign peers_needed = (peer_count_r > CAP_W) ? CAP_W : peer_count_r;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      my_address_r <= '0;
      my_port_r    <= '0;
      peer_count_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MY_ADDRESS: my_address_r <= cfg_wdata;
        CFG_MY_PORT:    my_port_r    <= cfg_wdata[PORT_W-1:0];
        CFG_PEER_COUNT: peer_count_r <= cfg_wdata[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_op_r   <= in_operation;
      in_addr_r <= in_sender_address;
      in_port_r <= in_sender_port;
    end
  end

  dla_step u_step (
    .op             (in_op_r),
    .sender_address (in_addr_r),
    .sender_port    (in_port_r),
    .my_address     (my_address_r),
    .my_port        (my_port_r),
    .peers_needed   (peers_needed),
    .cur            (state_r),
    .nxt            (state_nxt),
    .res            (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase          <= PH_AVAILABLE;
      state_r.holder_address <= '0;
      state_r.holder_port    <= '0;
      state_r.grants_seen    <= '0;
      out_valid_r            <= 1'b0;
    end else begin
      if (advance) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_send_kind        = res_r.send_kind;
  assign out_send_address     = res_r.send_address;
  assign out_send_port        = res_r.send_port;
  assign out_event_res        = res_r.event_res;
  assign out_lock_state       = res_r.lock_state;
  assign out_release_mismatch = res_r.release_mismatch;

endmodule

### src/dla_checker.sv
// Port-level checks for distributed_lock_arbiter_unit, bound to the top level.
// Depends on dla_pkg.
`timescale 1ns / 1ps

module dla_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [2:0]                    out_send_kind,
  input logic [dla_pkg::ADDR_W-1:0]    out_send_address,
  input logic [dla_pkg::PORT_W-1:0]    out_send_port,
  input logic [1:0]                    out_event_res,
  input logic [1:0]                    out_lock_state,
  input logic                          out_release_mismatch
);
  import dla_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_send_kind) &&
    $stable(out_send_address) && $stable(out_send_port) &&
    $stable(out_event_res) && $stable(out_lock_state) &&
    $stable(out_release_mismatch))
    else $error("result changed while stalled");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_send_kind == SEND_NONE) |->
    (out_send_address == '0) && (out_send_port == '0))
    else $error("empty broadcast carries an address");

  a_mismatch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_release_mismatch |->
    (out_event_res == EV_RELEASED) && (out_lock_state == PH_AVAILABLE))
    else $error("mismatch without a release");

  a_granted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res == EV_GRANTED) |-> (out_lock_state == PH_OURS))
    else $error("grant event but lock not ours");

  a_grant_sent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_send_kind == SEND_GRANT) |-> (out_lock_state == PH_REMOTE))
    else $error("grant sent but lock not held remotely");

endmodule

bind distributed_lock_arbiter_unit dla_checker u_dla_checker (.*);
